// ===== hw/rtl/billboard_quad_expander_top_assert.svh =====
// Assertion macros for the billboard quad expander.
`ifndef BILLBOARD_QUAD_EXPANDER_TOP_ASSERT_SVH
`define BILLBOARD_QUAD_EXPANDER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define BQE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BQE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BQE_ASSERT(label, prop, msg)
`define BQE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== hw/rtl/bqe_pkg.sv =====
package bqe_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int IN_W      = 240;
    localparam int OUT_W     = 232;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic        SCALE_ENABLE_RST = 1'b1;
    localparam logic [15:0] WORLD_SCALE_RST  = 16'd256;

    // quarter-wave sine polynomial, Q15
    localparam longint SIN_A = 51472;
    localparam longint SIN_B = 21024;
    localparam longint SIN_C = 2320;

    localparam int TRIG_W = 18;   // signed Q1.15 with room for +1.0 and -1.0
    localparam int MAG_W  = 17;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SCALE_ENABLE  = 2'd0,
        CFG_WORLD_SCALE_X = 2'd1,
        CFG_WORLD_SCALE_Y = 2'd2
    } bqe_cfg_addr_t;

    typedef struct packed {
        logic        scale_enable;
        logic [15:0] world_scale_x;
        logic [15:0] world_scale_y;
    } bqe_cfg_t;

    // input word, last field listed in the lowest bits
    typedef struct packed {
        logic [15:0] rotation;
        logic [31:0] color_argb;
        logic [15:0] uv_max_v;
        logic [15:0] uv_max_u;
        logic [15:0] uv_min_v;
        logic [15:0] uv_min_u;
        logic [15:0] size_y;
        logic [15:0] size_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } bqe_in_t;

    // output word, last field listed in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [1:0]  corner;
        logic [31:0] offset_y;
        logic [31:0] offset_x;
        logic [15:0] tex_v;
        logic [15:0] tex_u;
        logic [31:0] vert_color;
        logic [31:0] vert_z;
        logic [31:0] vert_y;
        logic [31:0] vert_x;
    } bqe_out_t;

    // one classified billboard between front and back
    typedef struct packed {
        logic [31:0]              pos_x;
        logic [31:0]              pos_y;
        logic [31:0]              pos_z;
        logic [31:0]              color;
        logic [15:0]              uv_min_u;
        logic [15:0]              uv_min_v;
        logic [15:0]              uv_max_u;
        logic [15:0]              uv_max_v;
        logic [31:0]              size_x;
        logic [31:0]              size_y;
        logic signed [TRIG_W-1:0] sin_val;
        logic signed [TRIG_W-1:0] cos_val;
    } bqe_entry_t;

    function automatic longint quarter_sine(input longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 15;
        t  = (SIN_C * x2) >>> 15;
        t  = SIN_B - t;
        t  = (x2 * t) >>> 15;
        t  = SIN_A - t;
        return (x * t) >>> 15;
    endfunction

endpackage

// ===== hw/rtl/billboard_quad_expander_top.sv =====
// Billboard quad expander: each enabled billboard word becomes four vertex words, corners
// (min.u,max.v), (max.u,max.v), (max.u,min.v), (min.u,min.v), the fourth one with tlast.
// Sustained rate is one billboard per four vertex words, set by the corner sequencer, which issues
// one vertex word per cycle while m_axis_tready is high; disabled billboards are taken one per
// cycle while the front stage is not stalled and yield nothing. With the back end idle, the first
// vertex word passes size multiply and sine ROM read, queue, corner products, output register. A
// short queue sits between the classifying front and the corner sequencer. Config registers:
// 0 scale_enable, 1 world_scale_x, 2 world_scale_y; write them only while the block is idle.
`include "billboard_quad_expander_top_assert.svh"

module billboard_quad_expander_top
    import bqe_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // pos_x, pos_y, pos_z, size_x, size_y,
                                                  // uv_min_u, uv_min_v, uv_max_u, uv_max_v,
                                                  // color_argb, rotation
    input  logic                  s_axis_tuser,   // enabled
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // vert_x, vert_y, vert_z, vert_color, tex_u,
                                                  // tex_v, offset_x, offset_y, corner
    output logic                  m_axis_tlast    // last
);

    bqe_cfg_t   cfg_reg;
    logic       push_valid;
    logic       push_ready;
    bqe_entry_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    bqe_entry_t pop_data;
    bqe_out_t   out_word;
    logic [1:0] out_corner;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_enable  <= SCALE_ENABLE_RST;
            cfg_reg.world_scale_x <= WORLD_SCALE_RST;
            cfg_reg.world_scale_y <= WORLD_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SCALE_ENABLE:  cfg_reg.scale_enable  <= cfg_data[0];
                CFG_WORLD_SCALE_X: cfg_reg.world_scale_x <= cfg_data;
                CFG_WORLD_SCALE_Y: cfg_reg.world_scale_y <= cfg_data;
                default:           ;
            endcase
        end
    end

    bqe_front #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    bqe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bqe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign out_word   = bqe_out_t'(m_axis_tdata);
    assign out_corner = out_word.corner;

    `BQE_ASSERT(a_corner_follows, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && (out_corner == $past(out_corner) + 2'd1)), "corner word did not follow in the next cycle")
    `BQE_ASSERT(a_last_on_fourth, m_axis_tvalid |-> (m_axis_tlast == (out_corner == 2'd3)), "tlast does not match the fourth corner")
    `BQE_ASSERT_ALWAYS(a_reset_quiet, (!rst_n ##1 !rst_n) |-> (!m_axis_tvalid && !push_valid && !pop_valid), "pipeline not empty in reset")

endmodule

// ===== hw/rtl/bqe_fifo.sv =====
module bqe_fifo
    import bqe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  bqe_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output bqe_entry_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bqe_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/bqe_front.sv =====
module bqe_front
    import bqe_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  bqe_cfg_t        cfg,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,   // pos_x, pos_y, pos_z, size_x, size_y, uv_min_u,
                                            // uv_min_v, uv_max_u, uv_max_v, color_argb, rotation
    input  logic            s_axis_tuser,   // enabled
    output logic            push_valid,
    input  logic            push_ready,
    output bqe_entry_t      push_data
);

    localparam int QB     = SINE_TABLE_BITS - 2;
    localparam int QDEPTH = (1 << QB) + 1;
    localparam int ADDR_W = QB + 1;

    typedef logic [MAG_W-1:0] qtab_t [QDEPTH];

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int k = 0; k < QDEPTH; k++)
        begin
            tab[k] = MAG_W'(quarter_sine(longint'(k) << (15 - QB)));
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    bqe_in_t                    in_word;
    logic [SINE_TABLE_BITS-1:0] angle_idx;
    logic [1:0]                 sin_quad;
    logic [1:0]                 cos_quad;
    logic [QB-1:0]              frac;
    logic [ADDR_W-1:0]          sin_addr;
    logic [ADDR_W-1:0]          cos_addr;
    logic [31:0]                scaled_x;
    logic [31:0]                scaled_y;
    logic                       advance;
    logic                       take;

    logic                       valid_reg;
    bqe_entry_t                 stage_reg;
    logic [MAG_W-1:0]           sin_mag_reg;
    logic [MAG_W-1:0]           cos_mag_reg;
    logic                       sin_neg_reg;
    logic                       cos_neg_reg;

    assign in_word   = bqe_in_t'(s_axis_tdata);
    assign angle_idx = in_word.rotation[15 -: SINE_TABLE_BITS];
    assign sin_quad  = angle_idx[SINE_TABLE_BITS-1 -: 2];
    assign cos_quad  = sin_quad + 2'd1;
    assign frac      = angle_idx[QB-1:0];
    // odd quadrants read the table mirrored
    assign sin_addr  = sin_quad[0] ? (ADDR_W'(1 << QB) - ADDR_W'(frac)) : ADDR_W'(frac);
    assign cos_addr  = cos_quad[0] ? (ADDR_W'(1 << QB) - ADDR_W'(frac)) : ADDR_W'(frac);

    assign scaled_x = cfg.scale_enable ? (32'(in_word.size_x) * 32'(cfg.world_scale_x))
                                       : {8'd0, in_word.size_x, 8'd0};
    assign scaled_y = cfg.scale_enable ? (32'(in_word.size_y) * 32'(cfg.world_scale_y))
                                       : {8'd0, in_word.size_y, 8'd0};

    assign s_axis_tready = !valid_reg || push_ready;
    assign advance       = s_axis_tready;
    assign take          = advance && s_axis_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= s_axis_tvalid && s_axis_tuser;   // disabled words are dropped here
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.pos_x    <= in_word.pos_x;
            stage_reg.pos_y    <= in_word.pos_y;
            stage_reg.pos_z    <= in_word.pos_z;
            stage_reg.color    <= in_word.color_argb;
            stage_reg.uv_min_u <= in_word.uv_min_u;
            stage_reg.uv_min_v <= in_word.uv_min_v;
            stage_reg.uv_max_u <= in_word.uv_max_u;
            stage_reg.uv_max_v <= in_word.uv_max_v;
            stage_reg.size_x   <= scaled_x;
            stage_reg.size_y   <= scaled_y;
            stage_reg.sin_val  <= '0;
            stage_reg.cos_val  <= '0;
            sin_mag_reg        <= QTAB[sin_addr];
            cos_mag_reg        <= QTAB[cos_addr];
            sin_neg_reg        <= sin_quad[1];
            cos_neg_reg        <= cos_quad[1];
        end
    end

    always_comb
    begin
        push_data         = stage_reg;
        push_data.sin_val = sin_neg_reg ? -$signed({1'b0, sin_mag_reg})
                                        : $signed({1'b0, sin_mag_reg});
        push_data.cos_val = cos_neg_reg ? -$signed({1'b0, cos_mag_reg})
                                        : $signed({1'b0, cos_mag_reg});
    end

    assign push_valid = valid_reg;

endmodule

// ===== hw/rtl/bqe_back.sv =====
module bqe_back
    import bqe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  bqe_entry_t       pop_data,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // vert_x, vert_y, vert_z, vert_color, tex_u, tex_v,
                                             // offset_x, offset_y, corner
    output logic             m_axis_tlast    // last
);

    localparam int PROD_W = 33 + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int QUO_W  = SUM_W - 15;

    typedef enum logic [1:0] {
        CORNER_MIN_U_MAX_V = 2'd0,
        CORNER_MAX_U_MAX_V = 2'd1,
        CORNER_MAX_U_MIN_V = 2'd2,
        CORNER_MIN_U_MIN_V = 2'd3
    } corner_t;

    function automatic logic [31:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic signed [QUO_W-1:0] q;
        r = s + SUM_W'(16384);
        q = QUO_W'(r >>> 15);
        if (q > QUO_W'(32'sh7FFF_FFFF))
        begin
            return 32'h7FFF_FFFF;
        end
        else if (q < -QUO_W'(33'sh0_8000_0000))
        begin
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    logic                     busy_reg;
    corner_t                  corner_reg;
    logic signed [PROD_W-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    bqe_entry_t               item_reg;
    logic                     out_valid_reg;
    bqe_out_t                 out_reg;
    logic                     out_last_reg;

    logic                     out_free;
    logic                     emit;
    logic                     done;
    logic                     load;
    logic signed [SUM_W-1:0]  xc, ys, xs, yc;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic [15:0]              tex_u, tex_v;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emit      = busy_reg && out_free;
    assign done      = emit && (corner_reg == CORNER_MIN_U_MIN_V);
    assign pop_ready = !busy_reg || done;
    assign load      = pop_valid && pop_ready;

    assign xc = SUM_W'(xc_reg);
    assign ys = SUM_W'(ys_reg);
    assign xs = SUM_W'(xs_reg);
    assign yc = SUM_W'(yc_reg);

    always_comb
    begin
        case (corner_reg)
            CORNER_MIN_U_MAX_V:
            begin
                sum_x = ys - xc;
                sum_y = yc + xs;
                tex_u = item_reg.uv_min_u;
                tex_v = item_reg.uv_max_v;
            end
            CORNER_MAX_U_MAX_V:
            begin
                sum_x = xc + ys;
                sum_y = yc - xs;
                tex_u = item_reg.uv_max_u;
                tex_v = item_reg.uv_max_v;
            end
            CORNER_MAX_U_MIN_V:
            begin
                sum_x = xc - ys;
                sum_y = -yc - xs;
                tex_u = item_reg.uv_max_u;
                tex_v = item_reg.uv_min_v;
            end
            default:
            begin
                sum_x = -xc - ys;
                sum_y = xs - yc;
                tex_u = item_reg.uv_min_u;
                tex_v = item_reg.uv_min_v;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            corner_reg    <= CORNER_MIN_U_MAX_V;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg   <= 1'b1;
                corner_reg <= CORNER_MIN_U_MAX_V;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                corner_reg <= corner_t'(corner_reg + 2'd1);
            end
            if (out_free)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= pop_data;
            xc_reg   <= $signed({1'b0, pop_data.size_x}) * pop_data.cos_val;
            ys_reg   <= $signed({1'b0, pop_data.size_y}) * pop_data.sin_val;
            xs_reg   <= $signed({1'b0, pop_data.size_x}) * pop_data.sin_val;
            yc_reg   <= $signed({1'b0, pop_data.size_y}) * pop_data.cos_val;
        end
        if (emit)
        begin
            out_reg.pad        <= '0;
            out_reg.corner     <= corner_reg;
            out_reg.offset_x   <= round_sat(sum_x);
            out_reg.offset_y   <= round_sat(sum_y);
            out_reg.tex_u      <= tex_u;
            out_reg.tex_v      <= tex_v;
            out_reg.vert_color <= item_reg.color;
            out_reg.vert_x     <= item_reg.pos_x;
            out_reg.vert_y     <= item_reg.pos_y;
            out_reg.vert_z     <= item_reg.pos_z;
            out_last_reg       <= (corner_reg == CORNER_MIN_U_MIN_V);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== tb/billboard_quad_expander_top_test.sv =====
`timescale 1ns / 100ps

module billboard_quad_expander_top_test;
    import bqe_pkg::*;

    localparam int SINE_BITS = SINE_TABLE_BITS_DEF;
    localparam longint POLY_A = 51472;
    localparam longint POLY_B = 21024;
    localparam longint POLY_C = 2320;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct {
        bqe_in_t word;
        logic    enabled;
    } billboard_t;

    typedef struct {
        logic [31:0] vert_x;
        logic [31:0] vert_y;
        logic [31:0] vert_z;
        logic [31:0] vert_color;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [1:0]  corner;
        logic        last;
    } vertex_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKED,
        RX_PERIODIC
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;

    billboard_t  billboard_q[$];
    vertex_t     vertex_q[$];
    logic        scale_on = SCALE_ENABLE_RST;
    logic [15:0] scale_x = WORLD_SCALE_RST;
    logic [15:0] scale_y = WORLD_SCALE_RST;
    bit          failed = 1'b0;
    int unsigned cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    billboard_t  next_bb;
    bqe_out_t    seen;
    vertex_t     want;

    billboard_quad_expander_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint quarter_wave(input longint x);
        longint sq;
        longint acc;
        sq  = (x * x) >>> 15;
        acc = POLY_B - ((POLY_C * sq) >>> 15);
        acc = POLY_A - ((sq * acc) >>> 15);
        return (x * acc) >>> 15;
    endfunction

    // Q1.15 sine of an angle in table steps per turn
    function automatic longint turn_sine(input int unsigned idx);
        int unsigned wrapped;
        int unsigned quadrant;
        int unsigned phase;
        longint      x;
        longint      mag;
        wrapped  = idx % (1 << SINE_BITS);
        quadrant = wrapped >> (SINE_BITS - 2);
        phase    = wrapped & ((1 << (SINE_BITS - 2)) - 1);
        x        = longint'(phase) << (17 - SINE_BITS);
        if (quadrant[0])
            x = 32768 - x;
        mag = quarter_wave(x);
        return quadrant[1] ? -mag : mag;
    endfunction

    function automatic logic [31:0] round_q15_sat(input longint p);
        longint q;
        q = (p + 16384) >>> 15;
        if (q > longint'(32'sh7FFF_FFFF))
            q = 32'sh7FFF_FFFF;
        if (q < -longint'(64'sd2147483648))
            q = -longint'(64'sd2147483648);
        return q[31:0];
    endfunction

    task automatic expand_quad(input bqe_in_t w);
        longint      half_x;
        longint      half_y;
        longint      sin_v;
        longint      cos_v;
        longint      ax;
        longint      ay;
        int unsigned idx;
        vertex_t     vtx;
        if (scale_on)
        begin
            half_x = longint'(w.size_x) * longint'(scale_x);
            half_y = longint'(w.size_y) * longint'(scale_y);
        end
        else
        begin
            half_x = longint'(w.size_x) << 8;
            half_y = longint'(w.size_y) << 8;
        end
        idx   = w.rotation >> (16 - SINE_BITS);
        sin_v = turn_sine(idx);
        cos_v = turn_sine(idx + (1 << (SINE_BITS - 2)));
        for (int k = 0; k < 4; k++)
        begin
            ax = (k == 0 || k == 3) ? -half_x : half_x;
            ay = (k < 2) ? half_y : -half_y;
            vtx.vert_x     = w.pos_x;
            vtx.vert_y     = w.pos_y;
            vtx.vert_z     = w.pos_z;
            vtx.vert_color = w.color_argb;
            vtx.tex_u      = (k == 0 || k == 3) ? w.uv_min_u : w.uv_max_u;
            vtx.tex_v      = (k < 2) ? w.uv_max_v : w.uv_min_v;
            vtx.offset_x   = round_q15_sat(ax * cos_v + ay * sin_v);
            vtx.offset_y   = round_q15_sat(ay * cos_v - ax * sin_v);
            vtx.corner     = k[1:0];
            vtx.last       = (k == 3);
            vertex_q.insert(vertex_q.size(), vtx);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %h, got %h", name, exp, act);
            failed = 1'b1;
        end
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bqe_in_t random_billboard();
        bqe_in_t w;
        w.pos_x      = $urandom;
        w.pos_y      = $urandom;
        w.pos_z      = $urandom;
        w.size_x     = pick16();
        w.size_y     = pick16();
        w.uv_min_u   = pick16();
        w.uv_min_v   = pick16();
        w.uv_max_u   = pick16();
        w.uv_max_v   = pick16();
        w.color_argb = $urandom;
        w.rotation   = 16'($urandom);
        return w;
    endfunction

    function automatic void add_billboard(input bqe_in_t w, input logic en);
        billboard_t bb;
        bb.word    = w;
        bb.enabled = en;
        billboard_q.insert(billboard_q.size(), bb);
    endfunction

    task automatic queue_random(input int n);
        logic en;
        for (int i = 0; i < n; i++)
        begin
            en = ($urandom_range(0, 7) != 0);
            add_billboard(random_billboard(), en);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_SCALE_ENABLE:  scale_on = data[0];
            CFG_WORLD_SCALE_X: scale_x = data;
            CFG_WORLD_SCALE_Y: scale_y = data;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (billboard_q.size() != 0 || s_axis_tvalid || vertex_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser)
                expand_quad(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (billboard_q.size() != 0)
                begin
                    next_bb = billboard_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_bb.word;
                    s_axis_tuser  <= next_bb.enabled;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(4, 80);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_CHOKED: m_axis_tready <= ($urandom_range(0, 5) == 0);
            default:   m_axis_tready <= (rx_left % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata;
            if (vertex_q.size() == 0)
            begin
                $error("unexpected vertex word, corner %0d", seen.corner);
                failed = 1'b1;
            end
            else
            begin
                want = vertex_q.pop_front();
                check_field("vert_x", want.vert_x, seen.vert_x);
                check_field("vert_y", want.vert_y, seen.vert_y);
                check_field("vert_z", want.vert_z, seen.vert_z);
                check_field("vert_color", want.vert_color, seen.vert_color);
                check_field("tex_u", want.tex_u, seen.tex_u);
                check_field("tex_v", want.tex_v, seen.tex_v);
                check_field("offset_x", want.offset_x, seen.offset_x);
                check_field("offset_y", want.offset_y, seen.offset_y);
                check_field("corner", want.corner, seen.corner);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        bqe_in_t     w;
        logic [15:0] fine_angles [4];
        fine_angles = '{16'h003F, 16'h0040, 16'hFFC0, 16'h3FFF};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, directed words
        w = '0;
        add_billboard(w, 1'b1);
        w = '1;
        add_billboard(w, 1'b1);
        add_billboard(random_billboard(), 1'b0);
        add_billboard('1, 1'b0);
        for (int r = 0; r < 8; r++)
        begin
            w = random_billboard();
            w.rotation = 16'(r << 13);
            add_billboard(w, 1'b1);
        end
        foreach (fine_angles[i])
        begin
            w = random_billboard();
            w.rotation = fine_angles[i];
            add_billboard(w, 1'b1);
        end
        w = random_billboard();
        w.pos_x      = 32'h8000_0000;
        w.pos_y      = 32'h7FFF_FFFF;
        w.pos_z      = '0;
        w.color_argb = '1;
        add_billboard(w, 1'b1);
        // inverted texture rectangle
        w = random_billboard();
        w.uv_min_u = 16'hFFFF;
        w.uv_max_u = 16'h0000;
        w.uv_min_v = 16'hC000;
        w.uv_max_v = 16'h4000;
        add_billboard(w, 1'b1);
        w = random_billboard();
        w.size_x = '1;
        w.size_y = '0;
        add_billboard(w, 1'b1);
        w.size_x = '0;
        w.size_y = '1;
        add_billboard(w, 1'b1);
        settle();

        // scaling off; upper data bits dropped; spare index ignored
        write_reg(CFG_SCALE_ENABLE, 16'hFFFE);
        write_reg(CFG_WORLD_SCALE_X, 16'($urandom));
        write_reg(CFG_WORLD_SCALE_Y, 16'($urandom));
        write_reg(CFG_SPARE, 16'hFFFF);
        queue_random(80);
        settle();

        // full scale: saturating offsets
        write_reg(CFG_SCALE_ENABLE, 16'h0003);
        write_reg(CFG_WORLD_SCALE_X, 16'hFFFF);
        write_reg(CFG_WORLD_SCALE_Y, 16'hFFFF);
        for (int r = 0; r < 4; r++)
        begin
            w = random_billboard();
            w.size_x   = '1;
            w.size_y   = '1;
            w.rotation = 16'((r << 14) + (r << 13));
            add_billboard(w, 1'b1);
        end
        queue_random(70);
        settle();

        write_reg(CFG_WORLD_SCALE_X, 16'h0000);
        write_reg(CFG_WORLD_SCALE_Y, 16'h0000);
        queue_random(50);
        settle();

        write_reg(CFG_WORLD_SCALE_X, 16'($urandom));
        write_reg(CFG_WORLD_SCALE_Y, 16'($urandom));
        queue_random(90);
        settle();

        write_reg(CFG_WORLD_SCALE_X, 16'hFFFF);
        write_reg(CFG_WORLD_SCALE_Y, 16'hFFFF);
        write_reg(CFG_SCALE_ENABLE, 16'h0000);
        queue_random(60);
        settle();

        write_reg(CFG_SCALE_ENABLE, 16'h0001);
        write_reg(CFG_WORLD_SCALE_X, 16'h0001);
        write_reg(CFG_WORLD_SCALE_Y, 16'hFFFF);
        queue_random(80);
        settle();

        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bqe_pkg.sv
hw/rtl/bqe_fifo.sv
hw/rtl/bqe_front.sv
hw/rtl/bqe_back.sv
hw/rtl/billboard_quad_expander_top.sv
tb/billboard_quad_expander_top_test.sv
